// ===== sv/cartesian_to_barycentric_top_macros.svh =====
// Assertion macros shared by the checker of the barycentric block.
`ifndef CARTESIAN_TO_BARYCENTRIC_TOP_MACROS_SVH
`define CARTESIAN_TO_BARYCENTRIC_TOP_MACROS_SVH

// A property that must hold at every clock edge outside reset.
`define CBC_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
        else $error("barycentric block assertion failed");

// When the first condition holds, the second must hold in the same cycle.
`define CBC_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("barycentric block implication failed");

`endif

// ===== sv/cbc_pkg.sv =====
// Types, constants and helper functions of the barycentric coordinate block.
`timescale 1ns / 1ps
package cbc_pkg;

    localparam int FRAC_BITS = 16;
    localparam int WORD_W    = 32;
    localparam int NUM_W     = WORD_W + FRAC_BITS;
    localparam int ADDR_W    = 3;

    localparam logic [WORD_W-1:0] FX_ONE = WORD_W'(1) << FRAC_BITS;

    localparam logic [0:0] REG_SPATIAL_MODE = 1'b0;
    localparam logic       MODE_SPATIAL_RST = 1'b1;

    typedef struct packed {
        logic signed [WORD_W-1:0] point_x;
        logic signed [WORD_W-1:0] point_y;
        logic signed [WORD_W-1:0] point_z;
        logic signed [WORD_W-1:0] corner_a_x;
        logic signed [WORD_W-1:0] corner_a_y;
        logic signed [WORD_W-1:0] corner_a_z;
        logic signed [WORD_W-1:0] corner_b_x;
        logic signed [WORD_W-1:0] corner_b_y;
        logic signed [WORD_W-1:0] corner_b_z;
        logic signed [WORD_W-1:0] corner_c_x;
        logic signed [WORD_W-1:0] corner_c_y;
        logic signed [WORD_W-1:0] corner_c_z;
    } t_in_req;

    typedef struct packed {
        logic signed [WORD_W-1:0] weight_a;
        logic signed [WORD_W-1:0] weight_b;
        logic signed [WORD_W-1:0] weight_c;
        logic                     degenerate;
    } t_out_req;

    // State handed from one divider cell to the next.
    typedef struct packed {
        logic              valid;
        logic              degen;
        logic              neg_b;
        logic              neg_c;
        logic [WORD_W-1:0] den_mag;
        logic [WORD_W-1:0] rem_b;
        logic [WORD_W-1:0] rem_c;
        logic [NUM_W-1:0]  num_b;
        logic [NUM_W-1:0]  num_c;
    } t_div_req;

    // Fixed-point product: full signed product shifted down, floor rounding.
    function automatic logic signed [WORD_W-1:0] fx_mul(
        input logic signed [WORD_W-1:0] a,
        input logic signed [WORD_W-1:0] b
    );
        logic signed [2*WORD_W-1:0] p;
        p = a * b;
        return p[FRAC_BITS+WORD_W-1:FRAC_BITS];
    endfunction

endpackage

// ===== sv/cbc_front.sv =====
// Front pipeline: differences, products, determinant and divider setup.
`timescale 1ns / 1ps
module cbc_front (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  logic             i_valid,
    input  logic             i_mode,
    input  cbc_pkg::t_in_req i_req,
    output cbc_pkg::t_div_req o_req
);
    import cbc_pkg::*;

    logic                     r1_valid, r2_valid, r3_valid, r4_valid, r5_valid, r6_valid;
    logic                     r1_mode, r2_mode, r3_mode, r4_mode;
    logic signed [WORD_W-1:0] r1_u [3];
    logic signed [WORD_W-1:0] r1_v [3];
    logic signed [WORD_W-1:0] r1_w [3];
    logic signed [WORD_W-1:0] r2_pm [6];
    logic signed [WORD_W-1:0] r2_sm [15];
    logic signed [WORD_W-1:0] r3_pden, r3_pnb, r3_pnc;
    logic signed [WORD_W-1:0] r3_d00, r3_d01, r3_d11, r3_d20, r3_d21;
    logic signed [WORD_W-1:0] r4_pden, r4_pnb, r4_pnc;
    logic signed [WORD_W-1:0] r4_sm [6];
    logic signed [WORD_W-1:0] r5_den, r5_nb, r5_nc;
    t_div_req                 r6_req, n6_req;
    logic [WORD_W-1:0]        abs_nb, abs_nc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
            r2_valid <= 1'b0;
            r3_valid <= 1'b0;
            r4_valid <= 1'b0;
            r5_valid <= 1'b0;
            r6_valid <= 1'b0;
        end else if (i_en) begin
            r1_valid <= i_valid;
            r2_valid <= r1_valid;
            r3_valid <= r2_valid;
            r4_valid <= r3_valid;
            r5_valid <= r4_valid;
            r6_valid <= r5_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            // Edge and offset vectors relative to the first corner.
            r1_mode <= i_mode;
            r1_u[0] <= i_req.corner_b_x - i_req.corner_a_x;
            r1_u[1] <= i_req.corner_b_y - i_req.corner_a_y;
            r1_u[2] <= i_req.corner_b_z - i_req.corner_a_z;
            r1_v[0] <= i_req.corner_c_x - i_req.corner_a_x;
            r1_v[1] <= i_req.corner_c_y - i_req.corner_a_y;
            r1_v[2] <= i_req.corner_c_z - i_req.corner_a_z;
            r1_w[0] <= i_req.point_x - i_req.corner_a_x;
            r1_w[1] <= i_req.point_y - i_req.corner_a_y;
            r1_w[2] <= i_req.point_z - i_req.corner_a_z;

            // Planar cross product terms.
            r2_mode  <= r1_mode;
            r2_pm[0] <= fx_mul(r1_u[0], r1_v[1]);
            r2_pm[1] <= fx_mul(r1_u[1], r1_v[0]);
            r2_pm[2] <= fx_mul(r1_w[0], r1_v[1]);
            r2_pm[3] <= fx_mul(r1_w[1], r1_v[0]);
            r2_pm[4] <= fx_mul(r1_u[0], r1_w[1]);
            r2_pm[5] <= fx_mul(r1_u[1], r1_w[0]);
            // Spatial dot product terms.
            for (int k = 0; k < 3; k++) begin
                r2_sm[k]      <= fx_mul(r1_u[k], r1_u[k]);
                r2_sm[3 + k]  <= fx_mul(r1_u[k], r1_v[k]);
                r2_sm[6 + k]  <= fx_mul(r1_v[k], r1_v[k]);
                r2_sm[9 + k]  <= fx_mul(r1_w[k], r1_u[k]);
                r2_sm[12 + k] <= fx_mul(r1_w[k], r1_v[k]);
            end

            r3_mode <= r2_mode;
            r3_pden <= r2_pm[0] - r2_pm[1];
            r3_pnb  <= r2_pm[2] - r2_pm[3];
            r3_pnc  <= r2_pm[4] - r2_pm[5];
            r3_d00  <= r2_sm[0] + r2_sm[1] + r2_sm[2];
            r3_d01  <= r2_sm[3] + r2_sm[4] + r2_sm[5];
            r3_d11  <= r2_sm[6] + r2_sm[7] + r2_sm[8];
            r3_d20  <= r2_sm[9] + r2_sm[10] + r2_sm[11];
            r3_d21  <= r2_sm[12] + r2_sm[13] + r2_sm[14];

            r4_mode  <= r3_mode;
            r4_pden  <= r3_pden;
            r4_pnb   <= r3_pnb;
            r4_pnc   <= r3_pnc;
            r4_sm[0] <= fx_mul(r3_d00, r3_d11);
            r4_sm[1] <= fx_mul(r3_d01, r3_d01);
            r4_sm[2] <= fx_mul(r3_d11, r3_d20);
            r4_sm[3] <= fx_mul(r3_d01, r3_d21);
            r4_sm[4] <= fx_mul(r3_d00, r3_d21);
            r4_sm[5] <= fx_mul(r3_d01, r3_d20);

            if (r4_mode) begin
                r5_den <= r4_sm[0] - r4_sm[1];
                r5_nb  <= r4_sm[2] - r4_sm[3];
                r5_nc  <= r4_sm[4] - r4_sm[5];
            end else begin
                r5_den <= r4_pden;
                r5_nb  <= r4_pnb;
                r5_nc  <= r4_pnc;
            end

            r6_req <= n6_req;
        end
    end

    // Divider setup: magnitudes, result signs and the scaled dividends.
    always_comb begin
        abs_nb         = r5_nb[WORD_W-1] ? WORD_W'(-r5_nb) : WORD_W'(r5_nb);
        abs_nc         = r5_nc[WORD_W-1] ? WORD_W'(-r5_nc) : WORD_W'(r5_nc);
        n6_req         = '0;
        n6_req.valid   = r5_valid;
        n6_req.degen   = (r5_den == '0);
        n6_req.neg_b   = r5_nb[WORD_W-1] ^ r5_den[WORD_W-1];
        n6_req.neg_c   = r5_nc[WORD_W-1] ^ r5_den[WORD_W-1];
        n6_req.den_mag = r5_den[WORD_W-1] ? WORD_W'(-r5_den) : WORD_W'(r5_den);
        n6_req.num_b   = {abs_nb, FRAC_BITS'(0)};
        n6_req.num_c   = {abs_nc, FRAC_BITS'(0)};
    end

    always_comb begin
        o_req       = r6_req;
        o_req.valid = r6_valid;
    end

endmodule

// ===== sv/cbc_div_cell.sv =====
// One restoring division step for both weights, registered.
`timescale 1ns / 1ps
module cbc_div_cell (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  cbc_pkg::t_div_req i_req,
    output cbc_pkg::t_div_req o_req
);
    import cbc_pkg::*;

    t_div_req          r_req, n_req;
    logic [WORD_W:0]   rem_b_s, rem_c_s, den_x;
    logic              bit_b, bit_c;

    always_comb begin
        n_req   = i_req;
        den_x   = {1'b0, i_req.den_mag};
        rem_b_s = {i_req.rem_b, i_req.num_b[NUM_W-1]};
        rem_c_s = {i_req.rem_c, i_req.num_c[NUM_W-1]};
        bit_b   = (rem_b_s >= den_x);
        bit_c   = (rem_c_s >= den_x);
        n_req.rem_b = bit_b ? WORD_W'(rem_b_s - den_x) : rem_b_s[WORD_W-1:0];
        n_req.rem_c = bit_c ? WORD_W'(rem_c_s - den_x) : rem_c_s[WORD_W-1:0];
        n_req.num_b = {i_req.num_b[NUM_W-2:0], bit_b};
        n_req.num_c = {i_req.num_c[NUM_W-2:0], bit_c};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_req.valid <= 1'b0;
        end else if (i_en) begin
            r_req <= n_req;
        end
    end

    assign o_req = r_req;

endmodule

// ===== sv/cartesian_to_barycentric_top.sv =====
// Top level of the barycentric coordinate block: config port, pipeline, output.
`timescale 1ns / 1ps
// Usage
// The input channel (i_in_valid, i_in_req, o_in_stall) takes one request holding a
// query point and three triangle corners in signed 16.16. The output channel
// (o_out_valid, o_out_req, i_out_stall) returns three weights and a degenerate
// flag for every request, in the order the requests were taken.
// The APB-style port holds one register, spatial_mode at byte address 0, which
// selects the planar form (0) or the spatial form (1). It resets to 1 and should
// only be written while no request is in flight.
// A request passes six front stages, one divider cell per dividend bit (48
// cells, set by the 32 integer plus 16 fraction bits of the scaled numerator),
// and the output register on its way from acceptance to o_out_valid.
// Throughput is one request per cycle unless the output stalls; the divider chain
// of cells sets it, each cell retiring one quotient bit of both weights per cycle.
// When the output holds a result and the receiver stalls, the whole pipeline
// freezes and o_in_stall is raised in the same cycle; nothing is lost.
// Reset is synchronous and active low; it clears every valid bit and sets the
// mode register to the spatial form.
module cartesian_to_barycentric_top (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    input  cbc_pkg::t_in_req             i_in_req,
    output logic                         o_in_stall,
    output logic                         o_out_valid,
    output cbc_pkg::t_out_req            o_out_req,
    input  logic                         i_out_stall,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [cbc_pkg::ADDR_W-1:0]   paddr,
    input  logic [cbc_pkg::WORD_W-1:0]   pwdata,
    output logic [cbc_pkg::WORD_W-1:0]   prdata,
    output logic                         pready
);
    import cbc_pkg::*;

    logic              r_mode;
    logic              en;
    logic              r_out_valid;
    t_out_req          r_out_req, n_out_req;
    t_div_req          chain [NUM_W+1];
    logic [WORD_W-1:0] qb, qc, wb, wc;

    // Register index is the byte address divided by four.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_SPATIAL_RST;
        end else if (psel && penable && pwrite && pready
                     && (paddr[ADDR_W-1:2] == REG_SPATIAL_MODE)) begin
            r_mode <= pwdata[0];
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr[ADDR_W-1:2] == REG_SPATIAL_MODE) ? WORD_W'(r_mode) : '0;

    // The pipeline moves as a whole unless a finished result is held.
    assign en         = !(r_out_valid && i_out_stall);
    assign o_in_stall = !en;

    cbc_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (i_in_valid),
        .i_mode  (r_mode),
        .i_req   (i_in_req),
        .o_req   (chain[0])
    );

    // One cell per dividend bit; after the last cell the dividend registers
    // hold the quotient magnitudes.
    for (genvar g = 0; g < NUM_W; g++) begin : g_cell
        cbc_div_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_req   (chain[g]),
            .o_req   (chain[g+1])
        );
    end

    // Apply the signs, derive the first weight, and on a degenerate triangle zero the
    // weights and raise the degenerate flag.
    always_comb begin
        qb = chain[NUM_W].num_b[WORD_W-1:0];
        qc = chain[NUM_W].num_c[WORD_W-1:0];
        wb = chain[NUM_W].neg_b ? WORD_W'(-qb) : qb;
        wc = chain[NUM_W].neg_c ? WORD_W'(-qc) : qc;
        if (chain[NUM_W].degen) begin
            n_out_req.weight_a   = '0;
            n_out_req.weight_b   = '0;
            n_out_req.weight_c   = '0;
            n_out_req.degenerate = 1'b1;
        end else begin
            n_out_req.weight_a   = FX_ONE - wb - wc;
            n_out_req.weight_b   = wb;
            n_out_req.weight_c   = wc;
            n_out_req.degenerate = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_out_valid <= chain[NUM_W].valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out_req <= n_out_req;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_req   = r_out_req;

endmodule

// ===== sv/cbc_checker.sv =====
// Port-level checker of the barycentric block and its bind statement.
`timescale 1ns / 1ps
`include "cartesian_to_barycentric_top_macros.svh"
module cbc_checker (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       o_in_stall,
    input logic                       o_out_valid,
    input cbc_pkg::t_out_req          o_out_req,
    input logic                       i_out_stall,
    input logic                       pready
);
    import cbc_pkg::*;

    `CBC_ASSERT_IMPL(a_hold_valid, i_clk, i_rst_n, o_out_valid && i_out_stall, ##1 o_out_valid)
    `CBC_ASSERT_IMPL(a_stall_cause, i_clk, i_rst_n, o_in_stall, o_out_valid && i_out_stall)
    `CBC_ASSERT_IMPL(a_degen_zero, i_clk, i_rst_n, o_out_valid && o_out_req.degenerate, o_out_req.weight_a == 0 && o_out_req.weight_b == 0 && o_out_req.weight_c == 0)
    `CBC_ASSERT(a_pready, i_clk, i_rst_n, pready)

endmodule

bind cartesian_to_barycentric_top cbc_checker u_cbc_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .o_out_req   (o_out_req),
    .i_out_stall (i_out_stall),
    .pready      (pready)
);
